@@ rtl/core/ale_pkg.sv @@
package ale_pkg;

  // Operation applied to the entry cells
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROTL
  } cell_op_t;

endpackage

@@ rtl/core/ale_cmp.sv @@
module ale_cmp #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge,
  output logic         eq
);

  logic [W:0] wide;

  // One subtractor gives the difference and the borrow; equality is a separate compare
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[W-1:0];
  assign ge   = ~wide[W];
  assign eq   = (a == b);

endmodule

@@ rtl/core/ale_cells.sv @@
module ale_cells import ale_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  cell_op_t                      op,
  input  logic [$clog2(DEPTH)-1:0]      pos,
  input  logic [$clog2(DEPTH+1)-1:0]    cnt,
  input  logic [DATA_WIDTH-1:0]         din,
  output logic [DATA_WIDTH-1:0]         head,
  output logic [DATA_WIDTH-1:0]         sel
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] e      [DEPTH];
  logic [DATA_WIDTH-1:0] e_next [DEPTH];
  logic [CW-1:0]         last;

  assign last = cnt - CW'(1);

  // At once, cells from pos go up (insert) or down (delete); rotate: left by one
  always_comb begin
    e_next = e;
    for (int i = 0; i < DEPTH; i++) begin
      case (op)
        CELL_INS: begin
          if (IW'(i) == pos) begin
            e_next[i] = din;
          end else if (IW'(i) > pos) begin
            e_next[i] = e[(i == 0) ? 0 : i - 1];
          end
        end
        CELL_DEL: begin
          if (IW'(i) >= pos && i < DEPTH - 1) begin
            e_next[i] = e[(i == DEPTH - 1) ? i : i + 1];
          end
        end
        CELL_ROTL: begin
          if (CW'(i) == last) begin
            e_next[i] = e[0];
          end else if (CW'(i) < last) begin
            e_next[i] = e[(i == DEPTH - 1) ? i : i + 1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    e <= e_next;
  end

  assign head = e[0];
  assign sel  = e[pos];

endmodule

@@ rtl/core/array_list_engine_core.sv @@
// Bounded ordered list of DEPTH signed words with one operation per beat.
// Accepts an item only when idle (item_stall low); the finished result sits in
// an output register, so the next item can be taken while it waits.
// Every item passes S_CHECK and S_FIN; on a nonempty list a search also passes
// S_SRCH, and a rotate S_DIV, S_STEPS and S_ROT (no S_ROT for a zero remainder).
// The single compare/subtract unit takes one division bit or one list element per
// cycle, and the cells turn the list by one per cycle.
// Entries are not cleared by reset; count, state and result_valid are.
module array_list_engine_core import ale_pkg::*; #(
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [2:0]         action,
  input  logic signed [31:0] value,
  input  logic [3:0]         position,
  input  logic [7:0]         rotate_amount,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [2:0]         status,
  output logic signed [31:0] data,
  output logic [2:0]         found_index,
  output logic [3:0]         entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int UW = (DATA_WIDTH > 8) ? DATA_WIDTH : 8;

  typedef enum logic [2:0] {
    ACT_INS_FRONT = 3'd0,
    ACT_INS_BACK  = 3'd1,
    ACT_INS_AT    = 3'd2,
    ACT_DEL_FRONT = 3'd3,
    ACT_DEL_BACK  = 3'd4,
    ACT_DEL_AT    = 3'd5,
    ACT_SEARCH    = 3'd6,
    ACT_ROTATE    = 3'd7
  } act_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_DIV,
    S_STEPS,
    S_ROT,
    S_FIN
  } state_t;

  state_t                state;
  act_t                  act;
  logic [DATA_WIDTH-1:0] key;
  logic [3:0]            pos_q;
  logic [7:0]            amt;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         idx;
  logic [7:0]            rem;
  logic [2:0]            bitn;
  logic [CW-1:0]         steps;
  status_t               st;
  logic [31:0]           dq;
  logic [CW-1:0]         fi;

  logic [7:0]            pe;
  logic [7:0]            trial;
  logic [UW-1:0]         ua;
  logic [UW-1:0]         ub;
  logic [UW-1:0]         u_diff;
  logic                  u_ge;
  logic                  u_eq;
  logic                  u_gt;
  logic                  is_ins;
  logic                  is_del;
  logic                  full;
  logic                  empty;
  cell_op_t              cop;
  logic [DATA_WIDTH-1:0] head;
  logic [DATA_WIDTH-1:0] sel;

  assign item_stall = (state != S_IDLE);
  assign is_ins = (act == ACT_INS_FRONT) || (act == ACT_INS_BACK) || (act == ACT_INS_AT);
  assign is_del = (act == ACT_DEL_FRONT) || (act == ACT_DEL_BACK) || (act == ACT_DEL_AT);
  assign full   = (cnt == CW'(DEPTH));
  assign empty  = (cnt == '0);
  assign u_gt   = u_ge && !u_eq;
  assign trial  = {rem[6:0], amt[bitn]};

  // Effective position of the operation
  always_comb begin
    case (act)
      ACT_INS_FRONT, ACT_DEL_FRONT: pe = '0;
      ACT_INS_BACK:                 pe = 8'(cnt);
      ACT_DEL_BACK:                 pe = 8'(cnt - CW'(1));
      default:                      pe = 8'(pos_q);
    endcase
  end

  // Operand select for the shared unit
  always_comb begin
    case (state)
      S_SRCH: begin
        ua = UW'(head);
        ub = UW'(key);
      end
      S_DIV: begin
        ua = UW'(trial);
        ub = UW'(cnt);
      end
      S_STEPS: begin
        ua = UW'(cnt);
        ub = UW'(rem);
      end
      default: begin
        ua = UW'(cnt);
        ub = UW'(pe);
      end
    endcase
  end

  ale_cmp #(.W(UW)) u_cmp (
    .a    (ua),
    .b    (ub),
    .diff (u_diff),
    .ge   (u_ge),
    .eq   (u_eq)
  );

  always_comb begin
    cop = CELL_HOLD;
    case (state)
      S_CHECK: begin
        if (is_ins && !full && u_ge) begin
          cop = CELL_INS;
        end else if (is_del && !empty && u_gt) begin
          cop = CELL_DEL;
        end
      end
      S_SRCH, S_ROT: cop = CELL_ROTL;
      default: cop = CELL_HOLD;
    endcase
  end

  ale_cells #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_cells (
    .clk  (clk),
    .op   (cop),
    .pos  (pe[IW-1:0]),
    .cnt  (cnt),
    .din  (key),
    .head (head),
    .sel  (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            act   <= act_t'(action);
            key   <= DATA_WIDTH'($unsigned(value));
            pos_q <= position;
            amt   <= rotate_amount;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          dq    <= '0;
          fi    <= '0;
          st    <= ST_OK;
          state <= S_FIN;
          if (is_ins) begin
            if (full) begin
              st <= ST_FULL;
            end else if (!u_ge) begin
              st <= ST_BADPOS;
            end else begin
              cnt <= cnt + CW'(1);
            end
          end else if (is_del) begin
            if (empty) begin
              st <= ST_EMPTY;
            end else if (!u_gt) begin
              st <= ST_BADPOS;
            end else begin
              cnt <= cnt - CW'(1);
              dq  <= 32'($signed(sel));
            end
          end else if (empty) begin
            st <= ST_EMPTY;
          end else if (act == ACT_SEARCH) begin
            st    <= ST_NOTFOUND;
            idx   <= '0;
            state <= S_SRCH;
          end else begin
            rem   <= '0;
            bitn  <= 3'd7;
            state <= S_DIV;
          end
        end
        S_SRCH: begin
          // Head is compared while the list turns left; a full turn restores it
          if (u_eq && st == ST_NOTFOUND) begin
            st <= ST_OK;
            fi <= idx;
          end
          idx <= idx + CW'(1);
          if (idx + CW'(1) == cnt) begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          // Restoring remainder, one amount bit per cycle
          rem  <= u_ge ? u_diff[7:0] : trial;
          bitn <= bitn - 3'd1;
          if (bitn == 3'd0) begin
            state <= S_STEPS;
          end
        end
        S_STEPS: begin
          // Right by r equals left by count - r
          steps <= u_diff[CW-1:0];
          state <= (rem == '0) ? S_FIN : S_ROT;
        end
        S_ROT: begin
          steps <= steps - CW'(1);
          if (steps == CW'(1)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!result_valid || !result_stall) begin
            status       <= st;
            data         <= dq;
            found_index  <= 3'(fi);
            entry_count  <= 4'(cnt);
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("entry count above depth");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < 8'(cnt))
    else $error("remainder not below count");

  a_rot_steps: assert property (@(posedge clk) disable iff (rst)
    state == S_ROT |-> (steps != '0) && (steps < cnt))
    else $error("rotation step count out of range");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |-> entry_count == 4'(DEPTH))
    else $error("full status with list not full");

  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && data != '0 |-> status == ST_OK)
    else $error("nonzero data on failed operation");

endmodule
